// ===== rtl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared sizes, codes, character tables and decode result type for the
// keypad scan press classifier.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int ROWS     = 5;
  localparam int COLS     = 4;
  localparam int KEYS     = ROWS * COLS;
  localparam int SNAP_W   = 20;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 2;
  localparam int CODE_W   = 5;
  localparam int COUNT_W  = 16;
  localparam int CHAR_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int TAB_SIZE = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd1;

  localparam logic [COUNT_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [COUNT_W-1:0] REPEAT_RST     = 16'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

  // Keys that auto-repeat when held
  localparam logic [CODE_W-1:0] KEY_REP_LO = 5'd16;
  localparam logic [CODE_W-1:0] KEY_REP_HI = 5'd17;

  localparam logic [CHAR_W-1:0] SHORT_TAB [TAB_SIZE] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h2E, 7'h3D, 7'h2B, 7'h2D, 7'h2A, 7'h2F, 7'h28, 7'h29, 7'h08, 7'h1B
  };
  localparam logic [CHAR_W-1:0] LONG_TAB [TAB_SIZE] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h2E, 7'h3D, 7'h2B, 7'h2D, 7'h5E, 7'h23, 7'h6C, 7'h72, 7'h08, 7'h1B
  };

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } dec_t;

  // Look up a key character; codes without a table entry give zero
  function automatic logic [CHAR_W-1:0] key_char_f(logic [CODE_W-1:0] code,
                                                   logic lng);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (int'(code) < TAB_SIZE) begin
      ch = lng ? LONG_TAB[code] : SHORT_TAB[code];
    end
    return ch;
  endfunction

endpackage

// ===== rtl/kps_decode.sv =====
// ----------------------------------------------------------------------------
// kps_decode
// Decode one key snapshot to a key code: lowest column of the column union,
// first row whose column set equals that union.
// ----------------------------------------------------------------------------
module kps_decode (
  input  logic [kps_pkg::SNAP_W-1:0] key_down,
  output kps_pkg::dec_t              dec
);

  logic [kps_pkg::COLS-1:0]  row_mask [kps_pkg::ROWS];
  logic [kps_pkg::COLS-1:0]  uni;
  logic [kps_pkg::COL_W-1:0] col;
  logic [kps_pkg::ROW_W-1:0] row;
  logic                      found;

  always_comb begin
    uni = '0;
    for (int r = 0; r < kps_pkg::ROWS; r++) begin
      row_mask[r] = key_down[r*kps_pkg::COLS +: kps_pkg::COLS];
      uni         = uni | row_mask[r];
    end
  end

  // Lowest pressed column, first matching row
  always_comb begin
    col   = '0;
    row   = '0;
    found = 1'b0;
    for (int c = kps_pkg::COLS - 1; c >= 0; c--) begin
      if (uni[c]) begin
        col = kps_pkg::COL_W'(c);
      end
    end
    for (int r = kps_pkg::ROWS - 1; r >= 0; r--) begin
      if (row_mask[r] == uni) begin
        row   = kps_pkg::ROW_W'(r);
        found = 1'b1;
      end
    end
  end

  assign dec.valid = (uni != '0) && found;
  assign dec.code  = kps_pkg::CODE_W'(row) * kps_pkg::CODE_W'(kps_pkg::COLS)
                   + kps_pkg::CODE_W'(col);

endmodule

// ===== rtl/keypad_scan_press_classifier.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_press_classifier
// Poll-by-poll keypad decoder with short/long press classification and
// auto-repeat of the two repeat keys.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_key_down[19:0]
// out      out  out_valid/out_ready  out_key_char[6:0], out_is_long
// cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// One poll per cycle sustained while the output register is free or draining.
// A poll is latched in the input register, then decoded and applied to the press
// state as it leaves that register, landing in the output register (out_valid).
// The input register advances whenever the output register is empty or being
// drained; a result held by out_ready low freezes the input register, and
// in_ready drops once that register is occupied.
// rst_n is synchronous, active low; it clears the press state and restores
// the register defaults (long 100, repeat 20). cfg_ready is always high.
// ----------------------------------------------------------------------------
module keypad_scan_press_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kps_pkg::SNAP_W-1:0]    in_key_down,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kps_pkg::CHAR_W-1:0]    out_key_char,
  output logic                          out_is_long,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kps_pkg::COUNT_W-1:0]   cfg_data
);

  // Configuration registers
  logic [kps_pkg::COUNT_W-1:0] long_polls_r;
  logic [kps_pkg::COUNT_W-1:0] repeat_polls_r;

  // Input register
  logic                        s1_valid_r;
  logic [kps_pkg::SNAP_W-1:0]  s1_key_r;

  // Press state
  logic                        held_r,         held_nxt;
  logic [kps_pkg::CODE_W-1:0]  held_key_r,     held_key_nxt;
  logic [kps_pkg::COUNT_W-1:0] hold_count_r,   hold_count_nxt;
  logic                        repeat_valid_r, repeat_valid_nxt;
  logic [kps_pkg::CODE_W-1:0]  repeat_key_r,   repeat_key_nxt;

  // Output register
  logic                        out_valid_r;
  logic [kps_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_long_r;

  kps_pkg::dec_t               dec;
  logic                        advance;
  logic                        s1_fire;
  logic                        emit;
  logic                        emit_long;
  logic [kps_pkg::COUNT_W-1:0] count_inc;
  logic                        rep_key;

  kps_decode u_decode (
    .key_down (s1_key_r),
    .dec      (dec)
  );

  // Processing stage moves when the result slot is free or draining
  assign advance   = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign count_inc = (hold_count_r == kps_pkg::COUNT_MAX) ? hold_count_r
                   : hold_count_r + kps_pkg::COUNT_W'(1);
  assign rep_key   = (held_key_r == kps_pkg::KEY_REP_LO) ||
                     (held_key_r == kps_pkg::KEY_REP_HI);

  // Press state update for the poll in the input register
  always_comb begin
    held_nxt         = held_r;
    held_key_nxt     = held_key_r;
    hold_count_nxt   = hold_count_r;
    repeat_valid_nxt = repeat_valid_r;
    repeat_key_nxt   = repeat_key_r;
    emit             = 1'b0;
    emit_long        = 1'b0;
    if (!held_r) begin
      if (!dec.valid) begin
        repeat_valid_nxt = 1'b0;
      end else begin
        held_nxt       = 1'b1;
        held_key_nxt   = dec.code;
        hold_count_nxt = '0;
      end
    end else begin
      hold_count_nxt = count_inc;
      if (repeat_valid_r && dec.valid && dec.code == repeat_key_r &&
          count_inc == repeat_polls_r) begin
        // repeat tick
        held_nxt  = 1'b0;
        emit      = 1'b1;
        emit_long = 1'b1;
      end else if (!repeat_valid_r && count_inc > long_polls_r && rep_key) begin
        // first emission of a held repeat key
        repeat_valid_nxt = 1'b1;
        repeat_key_nxt   = held_key_r;
        held_nxt         = 1'b0;
        emit             = 1'b1;
        emit_long        = 1'b1;
      end else if (!dec.valid) begin
        // release; a repeating key goes quiet
        held_nxt = 1'b0;
        if (!repeat_valid_r) begin
          emit      = 1'b1;
          emit_long = (count_inc >= long_polls_r);
        end else begin
          repeat_valid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_polls_r   <= kps_pkg::LONG_PRESS_RST;
      repeat_polls_r <= kps_pkg::REPEAT_RST;
      s1_valid_r     <= 1'b0;
      held_r         <= 1'b0;
      held_key_r     <= '0;
      hold_count_r   <= '0;
      repeat_valid_r <= 1'b0;
      repeat_key_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // Configuration write; unknown indexes drop
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kps_pkg::REG_LONG_PRESS) begin
          long_polls_r <= cfg_data;
        end else if (cfg_index == kps_pkg::REG_REPEAT) begin
          repeat_polls_r <= cfg_data;
        end
      end
      // Input register: load, advance or hold
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        held_r         <= held_nxt;
        held_key_r     <= held_key_nxt;
        hold_count_r   <= hold_count_nxt;
        repeat_valid_r <= repeat_valid_nxt;
        repeat_key_r   <= repeat_key_nxt;
      end
      // Output register
      if (advance) begin
        out_valid_r <= s1_fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key_r <= in_key_down;
    end
    if (s1_fire && emit) begin
      out_char_r <= kps_pkg::key_char_f(held_key_r, emit_long);
      out_long_r <= emit_long;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_char = out_char_r;
  assign out_is_long  = out_long_r;

`ifndef ASSERT_OFF
  // Only a timed press can produce a result
  a_emit_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit) |-> held_r)
    else $error("result produced without a held key");

  // Every emission ends the timed press
  a_emit_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit) |=> !held_r)
    else $error("held not cleared after emission");

  // Auto-repeat only ever tracks one of the repeat keys
  a_repeat_key: assert property (@(posedge clk) disable iff (!rst_n)
    repeat_valid_r |-> (repeat_key_r == kps_pkg::KEY_REP_LO ||
                        repeat_key_r == kps_pkg::KEY_REP_HI))
    else $error("repeat tracking a non-repeat key");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_char_r)))
    else $error("pending result lost");
`endif

endmodule
